### rtl/cpr_pkg.sv
// ----------------------------------------------------------------------------
// cpr_pkg
// Shared constants and types of the capture period to rpm tachometer.
// ----------------------------------------------------------------------------
`default_nettype none

package cpr_pkg;

  // Width of the capture down-counter that is actually used.
  localparam int CNT_BITS = 16;

  localparam int CAPTURE_W = 16;
  localparam int LIMIT_W   = 16;
  localparam int TICKS_W   = 24;
  localparam int SPEED_W   = 8;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RPM_SCALE    = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [LIMIT_W-1:0] EDGE_LIMIT_RST   = 16'd5000;
  localparam logic [TICKS_W-1:0] WINDOW_TICKS_RST = 24'd10000000;
  localparam logic [TICKS_W-1:0] RPM_SCALE_RST    = 24'd250000;

  // Job queue between the front and the divider.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Divider runs one quotient bit per cycle over the whole dividend.
  localparam int DIV_STEPS = TICKS_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  localparam logic [SPEED_W-1:0] SPEED_MAX = '1;

  typedef struct packed {
    logic [TICKS_W-1:0]  elapsed;
    logic [CNT_BITS-1:0] period;
    logic                done;
  } job_t;

endpackage

`default_nettype wire

### rtl/cpr_front.sv
// ----------------------------------------------------------------------------
// cpr_front
// Accepts capture transactions, tracks the edge state and builds jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module cpr_front
  import cpr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  input  wire logic [CAPTURE_W-1:0] capture_count,
  input  wire logic [LIMIT_W-1:0]   edge_limit,
  input  wire logic [TICKS_W-1:0]   window_ticks,
  input  wire logic                 q_full,
  output      logic                 q_push,
  output      job_t                 q_job
);

  logic [CNT_BITS-1:0] prev_capture;
  logic                have_prev;
  logic [TICKS_W-1:0]  elapsed_sum;
  logic [LIMIT_W-1:0]  edges_seen;
  logic                finished;

  logic                accept;
  logic                live;
  logic [CNT_BITS-1:0] cur;
  logic [CNT_BITS-1:0] period;
  logic [TICKS_W:0]    sum;
  logic [TICKS_W-1:0]  sum_sat;
  logic                reached;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign live     = !finished && (edges_seen < edge_limit);

  assign cur     = capture_count[CNT_BITS-1:0];
  assign period  = prev_capture - cur;
  assign sum     = {1'b0, elapsed_sum} + (TICKS_W+1)'(period);
  assign sum_sat = sum[TICKS_W] ? '1 : sum[TICKS_W-1:0];
  assign reached = sum_sat >= window_ticks;

  assign q_push        = accept && live && have_prev;
  assign q_job.elapsed = sum_sat;
  assign q_job.period  = period;
  assign q_job.done    = reached;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_capture <= '0;
      have_prev    <= 1'b0;
      elapsed_sum  <= '0;
      edges_seen   <= '0;
      finished     <= 1'b0;
    end else if (accept && live) begin
      edges_seen   <= edges_seen + 1'b1;
      prev_capture <= cur;
      have_prev    <= 1'b1;
      if (have_prev) begin
        elapsed_sum <= sum_sat;
        finished    <= reached;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/cpr_queue.sv
// ----------------------------------------------------------------------------
// cpr_queue
// Short first-in first-out job queue between the front and the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module cpr_queue
  import cpr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  output      logic full,
  input  wire logic pop,
  output      job_t head_job,
  output      logic empty
);

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full     = count == QCNT_W'(QUEUE_DEPTH);
  assign empty    = count == '0;
  assign head_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/cpr_back.sv
// ----------------------------------------------------------------------------
// cpr_back
// Takes jobs from the queue, divides the scale by the period one bit per
// cycle and holds the finished result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cpr_back
  import cpr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [TICKS_W-1:0] rpm_scale,
  input  wire logic               q_empty,
  input  wire job_t               q_head,
  output      logic               q_pop,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic [TICKS_W-1:0] elapsed_ticks,
  output      logic [SPEED_W-1:0] speed_rpm,
  output      logic               speed_clipped,
  output      logic               window_done
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;

  logic [1:0]          state;
  logic [DCNT_W-1:0]   step;
  logic [CNT_BITS-1:0] rem;
  logic [TICKS_W-1:0]  quo;
  logic [CNT_BITS-1:0] divisor;
  logic [TICKS_W-1:0]  job_elapsed;
  logic                job_done;
  logic                job_zero;

  logic [CNT_BITS:0]   trial;
  logic [CNT_BITS:0]   diff;
  logic                fits;
  logic                over;
  logic                out_free;

  // One restoring division step: bring down the next dividend bit.
  assign trial = {rem, quo[TICKS_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = trial >= {1'b0, divisor};
  assign over  = |quo[TICKS_W-1:SPEED_W];

  assign out_free = !out_valid || out_ready;
  assign q_pop    = (state == ST_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        job_elapsed <= q_head.elapsed;
        job_done    <= q_head.done;
        job_zero    <= q_head.period == '0;
        divisor     <= q_head.period;
        rem         <= '0;
        quo         <= rpm_scale;
        step        <= '0;
      end
      ST_DIV: begin
        rem  <= fits ? diff[CNT_BITS-1:0] : trial[CNT_BITS-1:0];
        quo  <= {quo[TICKS_W-2:0], fits};
        step <= step + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // A new result replaces a taken one in the same cycle.
      if (state == ST_LOAD && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            if (q_head.done || q_head.period == '0) begin
              state <= ST_LOAD;
            end else begin
              state <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (step == DCNT_W'(DIV_STEPS - 1)) begin
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register, loaded once the previous result has been taken.
  always_ff @(posedge clk) begin
    if (state == ST_LOAD && out_free) begin
      elapsed_ticks <= job_elapsed;
      window_done   <= job_done;
      priority if (job_done) begin
        speed_rpm     <= '0;
        speed_clipped <= 1'b0;
      end else if (job_zero || over) begin
        speed_rpm     <= SPEED_MAX;
        speed_clipped <= 1'b1;
      end else begin
        speed_rpm     <= quo[SPEED_W-1:0];
        speed_clipped <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/capture_period_to_rpm_top.sv
// ----------------------------------------------------------------------------
// capture_period_to_rpm_top
// Input capture tachometer: turns down-counter captures into rpm readings.
// ----------------------------------------------------------------------------
// Each capture transaction carries the down-counter value latched at one
// falling edge of the sensor. The first edge only primes the stored capture
// and gives no result; each later edge gives a period (previous minus
// current, modulo the counter size), adds it into a saturating elapsed tick
// sum and yields one result transaction with rpm_scale / period clipped at
// 255. The edge whose sum reaches window_ticks gives one last result with
// window_done set, and every later edge is accepted and dropped until reset,
// as are edges beyond edge_limit. The front takes a capture transaction
// whenever the two-entry job queue has room; priming and dropped edges
// make no job. A speed result is produced by a restoring divider that
// resolves one quotient bit per cycle: the job is taken from the queue head
// in the idle state, divided in 24 steps and loaded into the output register.
// Zero periods and the final window result skip the divider. The output
// register lets the divider start the next job while a result waits to be
// taken. Configuration registers are written through cfg_write, cfg_index
// and cfg_data; the user must do so only while the block is idle, which the
// block does not enforce. A write to an unknown index is ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module capture_period_to_rpm_top
  import cpr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // Configuration write port.
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [TICKS_W-1:0]   cfg_data,
  // Capture input channel.
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  input  wire logic [CAPTURE_W-1:0] capture_count,
  // Result channel.
  output      logic                 out_valid,
  input  wire logic                 out_ready,
  output      logic [TICKS_W-1:0]   elapsed_ticks,
  output      logic [SPEED_W-1:0]   speed_rpm,
  output      logic                 speed_clipped,
  output      logic                 window_done
);

  logic [LIMIT_W-1:0] edge_limit;
  logic [TICKS_W-1:0] window_ticks;
  logic [TICKS_W-1:0] rpm_scale;

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  job_t q_in_job;
  job_t q_head;

  // Configuration registers. Each is cut to its own width on a write.
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_limit   <= EDGE_LIMIT_RST;
      window_ticks <= WINDOW_TICKS_RST;
      rpm_scale    <= RPM_SCALE_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_EDGE_LIMIT:   edge_limit   <= cfg_data[LIMIT_W-1:0];
        REG_WINDOW_TICKS: window_ticks <= cfg_data;
        REG_RPM_SCALE:    rpm_scale    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The front owns all edge state and decides at accept time whether an
  // edge makes a job, so the queue only ever holds results to be produced.
  cpr_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .capture_count (capture_count),
    .edge_limit    (edge_limit),
    .window_ticks  (window_ticks),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_job         (q_in_job)
  );

  cpr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_in_job),
    .full     (q_full),
    .pop      (q_pop),
    .head_job (q_head),
    .empty    (q_empty)
  );

  cpr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .rpm_scale     (rpm_scale),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .elapsed_ticks (elapsed_ticks),
    .speed_rpm     (speed_rpm),
    .speed_clipped (speed_clipped),
    .window_done   (window_done)
  );

endmodule

`default_nettype wire

### dv/capture_period_to_rpm_top_tb.sv
// ----------------------------------------------------------------------------
// capture_period_to_rpm_top_tb
// Self-checking testbench for the input capture tachometer.
// ----------------------------------------------------------------------------
// Capture transactions are driven on the valid/ready input channel, and the
// expected rpm readings are worked out on the fly by a behavioral model of
// the tachometer kept inside this bench. A checker process compares every
// result transaction, field by field, with the oldest pending reading.
// Directed tests cover the counter extremes, zero periods, the clip boundary,
// the scale extremes, the window boundary, an unused register index and the
// edge limit. Random traffic follows with random idle gaps on both sides, a
// long receiver hold-off that backs the block up, and a final stream of long
// periods that drives the elapsed sum into saturation and closes the window.
// ----------------------------------------------------------------------------
`default_nettype none

module capture_period_to_rpm_top_tb;
  import cpr_pkg::*;

  // The only index outside the register map that the 2-bit index can reach.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // Cycles to let pass after the last expected result before touching the
  // registers: long enough for a divider pass, and dropped or priming
  // edges give no result to wait for.
  localparam int SETTLE_CYCLES = 48;

  // Far beyond the slowest legal run.
  localparam longint LIMIT_TIME = 64'd80_000_000;

  localparam logic [TICKS_W-1:0] TICKS_MAX = '1;

  typedef struct packed {
    logic [TICKS_W-1:0] elapsed;
    logic [SPEED_W-1:0] speed;
    logic               clipped;
    logic               done;
  } rpm_reading_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [TICKS_W-1:0]   cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [CAPTURE_W-1:0] capture_count;
  logic                 out_valid;
  logic                 out_ready;
  logic [TICKS_W-1:0]   elapsed_ticks;
  logic [SPEED_W-1:0]   speed_rpm;
  logic                 speed_clipped;
  logic                 window_done;

  capture_period_to_rpm_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .capture_count (capture_count),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .elapsed_ticks (elapsed_ticks),
    .speed_rpm     (speed_rpm),
    .speed_clipped (speed_clipped),
    .window_done   (window_done)
  );

  // Register copies of the tachometer model, starting at their reset values.
  logic [LIMIT_W-1:0]  lim_edges   = EDGE_LIMIT_RST;
  logic [TICKS_W-1:0]  win_ticks   = WINDOW_TICKS_RST;
  logic [TICKS_W-1:0]  scale_ticks = RPM_SCALE_RST;

  // Tachometer state of the model.
  logic [CNT_BITS-1:0] last_capture  = '0;
  logic                primed        = 1'b0;
  logic [TICKS_W-1:0]  tick_sum      = '0;
  logic [LIMIT_W-1:0]  edges_taken   = '0;
  logic                window_closed = 1'b0;

  // Readings still owed by the block, oldest first.
  rpm_reading_t pending_readings[$];

  // Traffic shaping: idle gaps on each side and the receiver hold-off.
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int rx_hold_cycles = 0;

  int mismatch_count = 0;
  int captures_taken = 0;
  int edges_dropped  = 0;
  int results_seen   = 0;
  int clipped_seen   = 0;
  int cfg_writes     = 0;

  // --------------------------------------------------------------------------
  // Clock, reset and the run limit.
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(LIMIT_TIME);
    $display("Timeout: %0d readings still pending after %0t.",
             pending_readings.size(), $time);
    $display("CHECKS FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Model of the tachometer. Called once for every capture transaction that
  // the block accepts, in acceptance order; it queues the reading that the
  // capture must produce, if any.
  // --------------------------------------------------------------------------
  function automatic void predict_reading(input logic [CAPTURE_W-1:0] value);
    logic [CNT_BITS-1:0] cur;
    logic [CNT_BITS-1:0] period;
    logic [TICKS_W:0]    total;
    logic [TICKS_W-1:0]  quotient;
    rpm_reading_t        r;
    captures_taken++;
    // Once the window has closed, or the edge budget is used up, the block
    // swallows edges without any effect on its state.
    if (window_closed || edges_taken >= lim_edges) begin
      edges_dropped++;
      return;
    end
    edges_taken++;
    cur = value[CNT_BITS-1:0];
    // The priming edge only stores the capture.
    if (!primed) begin
      last_capture = cur;
      primed = 1'b1;
      return;
    end
    // The counter runs down, so the period is previous minus current,
    // wrapping at the counter size.
    period = last_capture - cur;
    last_capture = cur;
    total = {1'b0, tick_sum} + (TICKS_W+1)'(period);
    tick_sum = total[TICKS_W] ? TICKS_MAX : total[TICKS_W-1:0];
    r.elapsed = tick_sum;
    if (tick_sum < win_ticks) begin
      r.done = 1'b0;
      if (period == '0) begin
        r.speed = SPEED_MAX;
        r.clipped = 1'b1;
      end else begin
        quotient = scale_ticks / TICKS_W'(period);
        r.clipped = (quotient > TICKS_W'(SPEED_MAX));
        r.speed = r.clipped ? SPEED_MAX : quotient[SPEED_W-1:0];
      end
    end else begin
      // The edge that reaches the window reports once, with no speed.
      window_closed = 1'b1;
      r.speed = '0;
      r.clipped = 1'b0;
      r.done = 1'b1;
    end
    pending_readings.push_back(r);
  endfunction

  // Random idle length: mostly none, often a few cycles, now and then long.
  function automatic int pick_gap(input bit enabled);
    int roll;
    roll = $urandom_range(0, 99);
    if (!enabled || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t, result %0d: %s", $time, results_seen, what);
    mismatch_count++;
  endtask

  // --------------------------------------------------------------------------
  // Capture sender. Every call starts right after a rising edge. Valid is
  // left high after acceptance so that back-to-back transactions never lower
  // and raise it in the same time step; an idle gap or drain_and_settle
  // lowers it.
  // --------------------------------------------------------------------------
  task automatic send_capture(input logic [CAPTURE_W-1:0] value);
    int gap;
    gap = pick_gap(tx_idle);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    capture_count <= value;
    do @(posedge clk); while (in_ready !== 1'b1);
    predict_reading(value);
  endtask

  // Sends the capture that lies the given number of ticks after the last one.
  task automatic send_period(input logic [CNT_BITS-1:0] period);
    send_capture(CAPTURE_W'(last_capture - period));
  endtask

  // Stops offering captures, waits for every owed reading and then lets the
  // block run dry, so that the registers can be written safely.
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [TICKS_W-1:0]   value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      REG_EDGE_LIMIT:   lim_edges = value[LIMIT_W-1:0];
      REG_WINDOW_TICKS: win_ticks = value;
      REG_RPM_SCALE:    scale_ticks = value;
      default: ;
    endcase
    cfg_writes++;
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Result receiver. A hold-off requested by a test takes priority; otherwise
  // ready drops for random stretches while receiver idling is enabled.
  // --------------------------------------------------------------------------
  initial begin : result_receiver
    int stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_cycles > 0) begin
        out_ready <= 1'b0;
        rx_hold_cycles--;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 99) < 30) stall_left = pick_gap(rx_idle);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker. Outputs are sampled at the edge where the transaction
  // completes, before any update scheduled for that edge takes effect.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    rpm_reading_t want;
    if (rst === 1'b0 && out_valid === 1'b1 && out_ready === 1'b1) begin
      results_seen++;
      if (pending_readings.size() == 0) begin
        report_mismatch("result transaction with no reading expected");
      end else begin
        want = pending_readings.pop_front();
        if (want.clipped) clipped_seen++;
        if (elapsed_ticks !== want.elapsed)
          report_mismatch($sformatf("elapsed_ticks %0d, expected %0d",
                                    elapsed_ticks, want.elapsed));
        if (speed_rpm !== want.speed)
          report_mismatch($sformatf("speed_rpm %0d, expected %0d",
                                    speed_rpm, want.speed));
        if (speed_clipped !== want.clipped)
          report_mismatch($sformatf("speed_clipped %b, expected %b",
                                    speed_clipped, want.clipped));
        if (window_done !== want.done)
          report_mismatch($sformatf("window_done %b, expected %b",
                                    window_done, want.done));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Runs on the reset register values: priming, zero period, full-scale
  // period, counter wrap, and both sides of the 255 rpm clip at the default
  // scale of 250000 (980 ticks gives exactly 255, 976 ticks gives 256).
  task automatic test_reset_defaults();
    send_capture(16'hFFFF);
    send_capture(16'hFFFF);
    send_capture(16'h0000);
    send_period(16'd1000);
    send_period(16'd980);
    send_period(16'd976);
    send_period(16'd1);
    send_period(16'hFFFF);
  endtask

  // A zero scale gives a zero quotient, yet a zero period still clips.
  // The largest scale clips even at the longest period.
  task automatic test_scale_extremes();
    drain_and_settle();
    write_reg(REG_RPM_SCALE, '0);
    send_period(16'd0);
    send_period(16'd7);
    send_period(16'hFFFF);
    drain_and_settle();
    write_reg(REG_RPM_SCALE, TICKS_MAX);
    send_period(16'hFFFF);
    send_period(16'd40000);
  endtask

  // Puts the window one tick beyond where the next edge lands, so that the
  // comparison is exercised just below its threshold without closing it.
  // A write to the unused index carries a value that would close the window
  // at once if it were taken as a window write.
  task automatic test_window_boundary();
    drain_and_settle();
    write_reg(REG_WINDOW_TICKS, tick_sum + 24'd501);
    write_reg(REG_UNUSED, 24'd1);
    send_period(16'd500);
    drain_and_settle();
    write_reg(REG_WINDOW_TICKS, TICKS_MAX);
  endtask

  // Lets two more captures through, then drops the rest; a zero limit drops
  // everything; the largest limit reopens the input for the rest of the run.
  task automatic test_edge_limit();
    drain_and_settle();
    write_reg(REG_EDGE_LIMIT, TICKS_W'(edges_taken + 2));
    repeat (4) send_period(LIMIT_W'($urandom_range(500, 3000)));
    drain_and_settle();
    write_reg(REG_EDGE_LIMIT, '0);
    repeat (2) send_period(16'd1234);
    drain_and_settle();
    write_reg(REG_EDGE_LIMIT, TICKS_W'(16'hFFFF));
  endtask

  // One random edge. Most are plausible motor periods with random content;
  // a few are zero or very short, and some are raw counter values that act as
  // noise. Periods shrink if the elapsed sum ever nears the window.
  task automatic send_random_edge();
    int roll;
    roll = $urandom_range(0, 99);
    if (tick_sum > 24'd12_000_000)
      send_period(CNT_BITS'($urandom_range(0, 255)));
    else if (roll < 5)
      send_capture(CAPTURE_W'($urandom_range(0, 16'hFFFF)));
    else if (roll < 10)
      send_period('0);
    else if (roll < 22)
      send_period(CNT_BITS'($urandom_range(1, 255)));
    else
      send_period(CNT_BITS'($urandom_range(256, 8000)));
  endtask

  task automatic test_random_traffic(input int count, input logic [TICKS_W-1:0] scale,
                                     input bit tx_gaps, input bit rx_gaps);
    drain_and_settle();
    write_reg(REG_RPM_SCALE, scale);
    tx_idle = tx_gaps;
    rx_idle = rx_gaps;
    repeat (count) send_random_edge();
  endtask

  // The receiver holds off while captures keep coming, so the
  // job queue and output register fill and the input stalls.
  task automatic test_backpressure();
    drain_and_settle();
    tx_idle = 1'b0;
    rx_hold_cycles = 400;
    repeat (24) send_period(CNT_BITS'($urandom_range(1500, 4000)));
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // Long periods drive the sum past the 24-bit range, where it saturates at
  // the full-scale window and closes it. Later edges must be swallowed.
  task automatic test_saturation_end();
    drain_and_settle();
    write_reg(REG_RPM_SCALE, TICKS_W'($urandom_range(1, 24'hFFFFFF)));
    while (!window_closed) send_period(CNT_BITS'($urandom_range(30000, 65535)));
    repeat (4) send_period(16'd2000);
  endtask

  // --------------------------------------------------------------------------
  // Sequence of the run.
  // --------------------------------------------------------------------------
  initial begin
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = REG_EDGE_LIMIT;
    cfg_data      = '0;
    in_valid      = 1'b0;
    capture_count = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_scale_extremes();
    test_window_boundary();
    test_edge_limit();
    test_random_traffic(290, RPM_SCALE_RST, 1'b1, 1'b1);
    test_random_traffic(280, TICKS_W'($urandom_range(1, 24'hFFFFFF)), 1'b0, 1'b0);
    test_backpressure();
    test_random_traffic(280, TICKS_W'($urandom_range(1, 20000)), 1'b1, 1'b0);
    test_random_traffic(280, TICKS_W'($urandom_range(20000, 2000000)), 1'b0, 1'b1);
    test_saturation_end();
    drain_and_settle();

    $display("Covered %0d capture transactions (%0d dropped) and %0d readings, %0d clipped.",
             captures_taken, edges_dropped, results_seen, clipped_seen);
    $display("Made %0d register writes; the window closed at %0d elapsed ticks.",
             cfg_writes, tick_sum);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
